FILE: src/atb_pkg.sv
`timescale 1ns / 1ps

package atb_pkg;

  // Addressing modes, as reported on every result of one request
  typedef enum logic [1:0] {
    MODE_CHS   = 2'd0,
    MODE_LBA28 = 2'd1,
    MODE_LBA48 = 2'd2
  } mode_t;

  // Task-file register identifiers, in the order they are written
  localparam logic [3:0] REG_DEVSEL   = 4'd0;
  localparam logic [3:0] REG_COUNT_HI = 4'd1;
  localparam logic [3:0] REG_LBA3     = 4'd2;
  localparam logic [3:0] REG_LBA4     = 4'd3;
  localparam logic [3:0] REG_LBA5     = 4'd4;
  localparam logic [3:0] REG_COUNT_LO = 4'd5;
  localparam logic [3:0] REG_LBA_LOW  = 4'd6;
  localparam logic [3:0] REG_LBA_MID  = 4'd7;
  localparam logic [3:0] REG_LBA_HIGH = 4'd8;
  localparam logic [3:0] REG_CMD      = 4'd9;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_LBA_SUPPORTED  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_IS_SLAVE = 1'b1;

  // Device select bases and command opcodes
  localparam logic [7:0] DEVSEL_CHS    = 8'hA0;
  localparam logic [7:0] DEVSEL_LBA    = 8'hE0;
  localparam logic [7:0] CMD_READ      = 8'h20;
  localparam logic [7:0] CMD_READ_EXT  = 8'h24;
  localparam logic [7:0] CMD_WRITE     = 8'h30;
  localparam logic [7:0] CMD_WRITE_EXT = 8'h34;

  // Division by 63 sectors per track: q = (addr * RECIP) >> RECIP_SHIFT,
  // exact for every address below 2^28.
  localparam int unsigned RECIP_SHIFT = 34;
  localparam int unsigned RECIP_W     = 29;
  localparam logic [RECIP_W-1:0] CHS_RECIP = 29'd272696337;
  localparam int unsigned LBA28_W     = 28;
  localparam int unsigned PROD_W      = LBA28_W + RECIP_W;
  localparam int unsigned TRACK_W     = PROD_W - RECIP_SHIFT;

  typedef struct packed {
    logic lba_supported;
    logic drive_is_slave;
  } cfg_t;

  // One classified request, ready for the register-write sequencer
  typedef struct packed {
    mode_t      mode;
    logic [7:0] devsel;
    logic [7:0] count;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] opcode;
  } cmd_t;

endpackage

FILE: src/atb_front.sv
`timescale 1ns / 1ps

module atb_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  logic          in_is_write,
  input  logic [31:0]   in_block_address,
  input  logic [7:0]    in_sector_count,
  input  atb_pkg::cfg_t cfg,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output atb_pkg::cmd_t cmd
);
  import atb_pkg::*;

  logic        a_valid_r, a_valid_nxt;
  logic        a_wr_r;
  logic [31:0] a_addr_r;
  logic [7:0]  a_cnt_r;
  logic        a_ready;
  mode_t       a_mode;
  logic [PROD_W-1:0] a_prod;

  logic        b_valid_r, b_valid_nxt;
  logic        b_wr_r;
  logic [31:0] b_addr_r;
  logic [7:0]  b_cnt_r;
  mode_t       b_mode_r;
  logic [TRACK_W-1:0] b_track_r;
  logic        b_ready;

  logic [7:0]  sector;
  logic [15:0] cyl;
  logic [3:0]  head;
  logic [7:0]  dev_base;

  assign b_ready   = !b_valid_r || cmd_ready;
  assign a_ready   = !a_valid_r || b_ready;
  assign in_full   = !a_ready;
  assign cmd_valid = b_valid_r;

  // Stage A: pick the mode and start the divide by 63
  always_comb begin
    priority if (|a_addr_r[31:28]) begin
      a_mode = MODE_LBA48;
    end else if (cfg.lba_supported) begin
      a_mode = MODE_LBA28;
    end else begin
      a_mode = MODE_CHS;
    end
    a_prod = PROD_W'(a_addr_r[LBA28_W-1:0]) * PROD_W'(CHS_RECIP);
  end

  assign a_valid_nxt = a_ready ? in_push : a_valid_r;
  assign b_valid_nxt = b_ready ? a_valid_r : b_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_push && a_ready) begin
      a_wr_r   <= in_is_write;
      a_addr_r <= in_block_address;
      a_cnt_r  <= in_sector_count;
    end
    if (a_valid_r && b_ready) begin
      b_wr_r    <= a_wr_r;
      b_addr_r  <= a_addr_r;
      b_cnt_r   <= a_cnt_r;
      b_mode_r  <= a_mode;
      b_track_r <= a_prod[PROD_W-1:RECIP_SHIFT];
    end
  end

  // Stage B: addr mod 63 = (addr - 64q + q) mod 64, since the remainder is below 63
  assign sector = {2'b00, b_addr_r[5:0] + b_track_r[5:0]} + 8'd1;
  assign cyl    = b_track_r[19:4];

  always_comb begin
    cmd        = '0;
    cmd.mode   = b_mode_r;
    cmd.count  = b_cnt_r;
    head       = 4'd0;
    dev_base   = DEVSEL_LBA;
    unique case (b_mode_r)
      MODE_LBA48: begin
        cmd.b0 = b_addr_r[7:0];
        cmd.b1 = b_addr_r[15:8];
        cmd.b2 = b_addr_r[23:16];
        cmd.b3 = b_addr_r[31:24];
      end
      MODE_LBA28: begin
        cmd.b0 = b_addr_r[7:0];
        cmd.b1 = b_addr_r[15:8];
        cmd.b2 = b_addr_r[23:16];
        head   = b_addr_r[27:24];
      end
      MODE_CHS: begin
        cmd.b0   = sector;
        cmd.b1   = cyl[7:0];
        cmd.b2   = cyl[15:8];
        head     = b_track_r[3:0];
        dev_base = DEVSEL_CHS;
      end
      default: begin
        dev_base = DEVSEL_CHS;
      end
    endcase
    cmd.devsel = dev_base | {3'b000, cfg.drive_is_slave, 4'b0000} | {4'b0000, head};
    if (b_wr_r) begin
      cmd.opcode = (b_mode_r == MODE_LBA48) ? CMD_WRITE_EXT : CMD_WRITE;
    end else begin
      cmd.opcode = (b_mode_r == MODE_LBA48) ? CMD_READ_EXT : CMD_READ;
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && !cmd_ready) |=> (b_valid_r && $stable(b_addr_r) && $stable(b_mode_r)))
    else $error("front stage B lost its request while stalled");

endmodule

FILE: src/atb_cmd_fifo.sv
`timescale 1ns / 1ps

module atb_cmd_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          push_ready,
  input  atb_pkg::cmd_t push_data,
  output logic          head_valid,
  input  logic          pop,
  output atb_pkg::cmd_t head_data
);
  import atb_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CNT_W'(DEPTH)) && ((count_r == '0) || (count_r == CNT_W'(DEPTH)) ||
    (wr_ptr_r != rd_ptr_r)))
    else $error("command queue fill count and pointers disagree");

endmodule

FILE: src/atb_back.sv
`timescale 1ns / 1ps

module atb_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  atb_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          out_empty,
  input  logic          out_pop,
  output logic [3:0]    out_reg_id,
  output logic [7:0]    out_reg_value,
  output logic [1:0]    out_addressing_mode,
  output logic          out_last_write
);
  import atb_pkg::*;

  logic [3:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [3:0] out_id_r;
  logic [7:0] out_val_r;
  mode_t      out_mode_r;
  logic       out_last_r;
  logic       adv, last;
  logic [7:0] step_val;

  assign last    = (step_r == REG_CMD);
  assign adv     = cmd_valid && (!out_valid_r || out_pop);
  assign cmd_pop = adv && last;

  always_comb begin
    unique case (step_r)
      REG_DEVSEL:   step_val = cmd.devsel;
      REG_COUNT_HI: step_val = 8'h00;
      REG_LBA3:     step_val = cmd.b3;
      REG_LBA4:     step_val = 8'h00;
      REG_LBA5:     step_val = 8'h00;
      REG_COUNT_LO: step_val = cmd.count;
      REG_LBA_LOW:  step_val = cmd.b0;
      REG_LBA_MID:  step_val = cmd.b1;
      REG_LBA_HIGH: step_val = cmd.b2;
      REG_CMD:      step_val = cmd.opcode;
      default:      step_val = 8'h00;
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    if (adv) begin
      priority if (last) begin
        step_nxt = REG_DEVSEL;
      end else if (step_r == REG_DEVSEL && cmd.mode != MODE_LBA48) begin
        step_nxt = REG_COUNT_LO;
      end else begin
        step_nxt = step_r + 4'd1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= REG_DEVSEL;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_id_r   <= step_r;
      out_val_r  <= step_val;
      out_mode_r <= cmd.mode;
      out_last_r <= last;
    end
  end

  assign out_empty           = !out_valid_r;
  assign out_reg_id          = out_id_r;
  assign out_reg_value       = out_val_r;
  assign out_addressing_mode = out_mode_r;
  assign out_last_write      = out_last_r;

  a_short_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_mode_r != MODE_LBA48) |->
    (out_id_r == REG_DEVSEL || out_id_r == REG_COUNT_LO || out_id_r == REG_LBA_LOW ||
     out_id_r == REG_LBA_MID || out_id_r == REG_LBA_HIGH || out_id_r == REG_CMD))
    else $error("high-order register written outside LBA48");

  a_run_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && last) |=> (step_r == REG_DEVSEL && out_last_r))
    else $error("sequencer did not restart after the command write");

endmodule

FILE: src/ata_taskfile_command_builder_unit.sv
// The first register write of an item reaches the result ports through front-end
// stages A and B, the command queue and the output register; the rest follow one
// a cycle while pop is held high. An LBA48 item makes 10 task-file writes and an
// LBA28 or CHS item 6, all emitted by the back-end sequencer.
// Reset (rst_n low, synchronous): queues and output empty, LBA support on, master drive.
`timescale 1ns / 1ps

module ata_taskfile_command_builder_unit #(
  parameter int unsigned CMD_QUEUE_DEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request side
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_is_write,
  input  logic [31:0]                    in_block_address,
  input  logic [7:0]                     in_sector_count,
  // register-write side
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [3:0]                     out_reg_id,
  output logic [7:0]                     out_reg_value,
  output logic [1:0]                     out_addressing_mode,
  output logic                           out_last_write,
  // configuration
  input  logic                           cfg_we,
  input  logic [atb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic                           cfg_wdata
);
  import atb_pkg::*;

  // Configuration registers; to be written only while the block is idle (the block
  // itself does not enforce this), so the front end may sample them at any stage of an item.
  logic lba_supported_r, lba_supported_nxt;
  logic drive_is_slave_r, drive_is_slave_nxt;
  cfg_t cfg;

  always_comb begin
    lba_supported_nxt  = lba_supported_r;
    drive_is_slave_nxt = drive_is_slave_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_LBA_SUPPORTED:  lba_supported_nxt  = cfg_wdata;
        CFG_DRIVE_IS_SLAVE: drive_is_slave_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lba_supported_r  <= 1'b1;
      drive_is_slave_r <= 1'b0;
    end else begin
      lba_supported_r  <= lba_supported_nxt;
      drive_is_slave_r <= drive_is_slave_nxt;
    end
  end

  assign cfg.lba_supported  = lba_supported_r;
  assign cfg.drive_is_slave = drive_is_slave_r;

  // Front end: take the item, choose the addressing mode, split the address into
  // task-file bytes (the CHS divide by 63 is a reciprocal multiply, registered
  // before the remainder is formed). One item per cycle while the queue has room.
  logic cmd_valid, cmd_ready;
  cmd_t front_cmd;

  atb_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_is_write      (in_is_write),
    .in_block_address (in_block_address),
    .in_sector_count  (in_sector_count),
    .cfg              (cfg),
    .cmd_valid        (cmd_valid),
    .cmd_ready        (cmd_ready),
    .cmd              (front_cmd)
  );

  // Short queue of classified requests: lets the front end keep accepting
  // while the back end is still emitting the previous run.
  logic head_valid, head_pop;
  cmd_t head_cmd;

  atb_cmd_fifo #(
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (cmd_valid),
    .push_ready (cmd_ready),
    .push_data  (front_cmd),
    .head_valid (head_valid),
    .pop        (head_pop),
    .head_data  (head_cmd)
  );

  // Back end: walk the register list of the head request into an output register,
  // one write per cycle while popped; drop the request after its command write.
  atb_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd_valid           (head_valid),
    .cmd                 (head_cmd),
    .cmd_pop             (head_pop),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_reg_id          (out_reg_id),
    .out_reg_value       (out_reg_value),
    .out_addressing_mode (out_addressing_mode),
    .out_last_write      (out_last_write)
  );

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import atb_pkg::*;

  // CHS geometry and the LBA48 switch-over point
  localparam logic [31:0] LBA48_BASE        = 32'h1000_0000;
  localparam logic [31:0] SECTORS_PER_TRACK = 32'd63;
  localparam logic [31:0] HEADS_PER_CYL     = 32'd16;

  localparam int SETTLE_CYCLES = 8;    // cycles left after the last write before a config change
  localparam int HOLD_CYCLES   = 250;  // long receiver hold-off, long enough to back up the input
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_ITEMS   = 15;
  localparam int REPORT_LIMIT  = 10;

  // One task-file register write, as seen on the result side
  typedef struct packed {
    logic [3:0] reg_id;
    logic [7:0] value;
    mode_t      mode;
    logic       last;
  } tf_write_t;

  // One request, plus the drive settings it runs under and, for hand-checked
  // rows, the mode, device select byte and opcode that must come out
  typedef struct packed {
    logic        lba_ok;
    logic        slave;
    logic        wr;
    logic [31:0] lba;
    logic [7:0]  count;
    logic        typed;
    mode_t       mode;
    logic [7:0]  devsel;
    logic [7:0]  opcode;
  } request_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_push = 1'b0;
  logic                 in_full;
  logic                 in_is_write = 1'b0;
  logic [31:0]          in_block_address = '0;
  logic [7:0]           in_sector_count = '0;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  logic [3:0]           out_reg_id;
  logic [7:0]           out_reg_value;
  logic [1:0]           out_addressing_mode;
  logic                 out_last_write;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_LBA_SUPPORTED;
  logic                 cfg_wdata = 1'b0;

  // Drive settings as the block should hold them (reset values)
  logic drive_lba_ok = 1'b1;
  logic drive_slave  = 1'b0;

  tf_write_t pending_writes[$];  // register writes still owed by the block, oldest first
  int        mismatches = 0;
  bit        hold_req = 1'b0;    // sender asks the receiver for one long hold-off

  always #4 clk = ~clk;

  ata_taskfile_command_builder_unit uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_is_write         (in_is_write),
    .in_block_address    (in_block_address),
    .in_sector_count     (in_sector_count),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_reg_id          (out_reg_id),
    .out_reg_value       (out_reg_value),
    .out_addressing_mode (out_addressing_mode),
    .out_last_write      (out_last_write),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  // Hand-checked and predictor-checked requests. Rows carrying typed values
  // pin the mode, device select byte and opcode; the rest of each sequence
  // comes from the predictor.
  request_t dir_rows[] = '{
    // reset settings: LBA on, master
    '{1'b1, 1'b0, 1'b0, 32'h0000_0000, 8'h00, 1'b1, MODE_LBA28, 8'hE0, CMD_READ},
    '{1'b1, 1'b0, 1'b1, 32'h0FFF_FFFF, 8'hFF, 1'b1, MODE_LBA28, 8'hEF, CMD_WRITE},
    '{1'b1, 1'b0, 1'b0, 32'h1000_0000, 8'h01, 1'b1, MODE_LBA48, 8'hE0, CMD_READ_EXT},
    '{1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF, 8'hFF, 1'b1, MODE_LBA48, 8'hE0, CMD_WRITE_EXT},
    '{1'b1, 1'b0, 1'b0, 32'h0A5A_5A5A, 8'h5A, 1'b0, MODE_CHS,   8'h00, 8'h00},
    '{1'b1, 1'b0, 1'b1, 32'h15A5_A5A5, 8'hA5, 1'b0, MODE_CHS,   8'h00, 8'h00},
    // CHS on the slave: first sector, last sector of a track, head and cylinder steps
    '{1'b0, 1'b1, 1'b0, 32'd0,         8'h01, 1'b1, MODE_CHS,   8'hB0, CMD_READ},
    '{1'b0, 1'b1, 1'b1, 32'd62,        8'h08, 1'b1, MODE_CHS,   8'hB0, CMD_WRITE},
    '{1'b0, 1'b1, 1'b0, 32'd63,        8'h10, 1'b1, MODE_CHS,   8'hB1, CMD_READ},
    '{1'b0, 1'b1, 1'b1, 32'd1007,      8'h20, 1'b1, MODE_CHS,   8'hBF, CMD_WRITE},
    '{1'b0, 1'b1, 1'b0, 32'd1008,      8'h40, 1'b0, MODE_CHS,   8'h00, 8'h00},
    // cylinder wraps past 16 bits here
    '{1'b0, 1'b1, 1'b1, 32'h0FFF_FFFF, 8'h80, 1'b0, MODE_CHS,   8'h00, 8'h00},
    // LBA48 still wins with LBA support off
    '{1'b0, 1'b1, 1'b0, 32'h1000_0000, 8'h00, 1'b1, MODE_LBA48, 8'hF0, CMD_READ_EXT},
    '{1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF, 8'hFF, 1'b1, MODE_LBA48, 8'hF0, CMD_WRITE_EXT},
    '{1'b1, 1'b1, 1'b0, 32'h0500_0000, 8'h03, 1'b1, MODE_LBA28, 8'hF5, CMD_READ},
    '{1'b1, 1'b1, 1'b1, 32'h0ABC_DEF0, 8'hC3, 1'b0, MODE_CHS,   8'h00, 8'h00},
    '{1'b0, 1'b0, 1'b0, 32'd0,         8'h00, 1'b1, MODE_CHS,   8'hA0, CMD_READ},
    '{1'b0, 1'b0, 1'b1, 32'h0FFF_FFFF, 8'hFF, 1'b0, MODE_CHS,   8'h00, 8'h00},
    '{1'b0, 1'b0, 1'b1, 32'h0012_3456, 8'h7E, 1'b0, MODE_CHS,   8'h00, 8'h00}
  };

  // Work out the ordered register writes for one request under the given settings
  function automatic void build_taskfile(input request_t rq, input logic lba_ok,
                                         input logic slave, output tf_write_t seq[$]);
    logic [31:0] track;
    logic [31:0] cyl;
    mode_t       m;
    logic [3:0]  head;
    logic [7:0]  b0, b1, b2, b3, dev, cmd;
    seq = {};
    if (rq.lba >= LBA48_BASE) begin
      m    = MODE_LBA48;
      b0   = rq.lba[7:0];
      b1   = rq.lba[15:8];
      b2   = rq.lba[23:16];
      b3   = rq.lba[31:24];
      head = 4'd0;
    end else if (lba_ok) begin
      m    = MODE_LBA28;
      b0   = rq.lba[7:0];
      b1   = rq.lba[15:8];
      b2   = rq.lba[23:16];
      b3   = 8'd0;
      head = rq.lba[27:24];
    end else begin
      track = rq.lba / SECTORS_PER_TRACK;
      cyl   = (track / HEADS_PER_CYL) & 32'h0000_FFFF;
      m     = MODE_CHS;
      b0    = 8'(rq.lba % SECTORS_PER_TRACK + 32'd1);  // sectors count from one
      b1    = cyl[7:0];
      b2    = cyl[15:8];
      b3    = 8'd0;
      head  = track[3:0];
    end
    dev = ((m == MODE_CHS) ? DEVSEL_CHS : DEVSEL_LBA) | {3'b000, slave, head};
    if (rq.wr) cmd = (m == MODE_LBA48) ? CMD_WRITE_EXT : CMD_WRITE;
    else       cmd = (m == MODE_LBA48) ? CMD_READ_EXT : CMD_READ;
    seq.push_back('{REG_DEVSEL, dev, m, 1'b0});
    if (m == MODE_LBA48) begin
      seq.push_back('{REG_COUNT_HI, 8'd0, m, 1'b0});
      seq.push_back('{REG_LBA3, b3, m, 1'b0});
      seq.push_back('{REG_LBA4, 8'd0, m, 1'b0});
      seq.push_back('{REG_LBA5, 8'd0, m, 1'b0});
    end
    seq.push_back('{REG_COUNT_LO, rq.count, m, 1'b0});
    seq.push_back('{REG_LBA_LOW, b0, m, 1'b0});
    seq.push_back('{REG_LBA_MID, b1, m, 1'b0});
    seq.push_back('{REG_LBA_HIGH, b2, m, 1'b0});
    seq.push_back('{REG_CMD, cmd, m, 1'b1});
  endfunction

  // Random request, weighted towards the mode boundaries and CHS track edges
  function automatic request_t random_request();
    request_t rq;
    rq       = '0;
    rq.wr    = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0, 1: rq.lba = $urandom;
      2:    rq.lba = $urandom & 32'h0FFF_FFFF;
      3:    rq.lba = $urandom_range(0, 5000);
      4:    rq.lba = $urandom_range(0, 1) ? LBA48_BASE - 32'($urandom_range(1, 4))
                                          : LBA48_BASE + 32'($urandom_range(0, 3));
      default:
        rq.lba = SECTORS_PER_TRACK * 32'($urandom_range(0, 4_000_000))
                 + ($urandom_range(0, 1) ? SECTORS_PER_TRACK - 32'd1 : 32'd0);
    endcase
    if ($urandom_range(0, 7) == 0) rq.count = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    else                           rq.count = 8'($urandom_range(0, 255));
    return rq;
  endfunction

  // Offer one item, hold it until accepted, then queue up the writes it owes
  task automatic issue_request(input request_t rq);
    tf_write_t seq[$];
    in_push          <= 1'b1;
    in_is_write      <= rq.wr;
    in_block_address <= rq.lba;
    in_sector_count  <= rq.count;
    do @(posedge clk); while (in_full);
    build_taskfile(rq, drive_lba_ok, drive_slave, seq);
    foreach (seq[i]) begin
      // hand-checked rows override what the predictor says for these fields
      if (rq.typed) begin
        seq[i].mode = rq.mode;
        if (seq[i].reg_id == REG_DEVSEL) seq[i].value = rq.devsel;
        if (seq[i].reg_id == REG_CMD)    seq[i].value = rq.opcode;
      end
      pending_writes.push_back(seq[i]);
    end
  endtask

  // Drop push for a gap; a zero gap keeps push high into the next item
  task automatic rest_sender(input int cycles);
    if (cycles > 0) begin
      in_push <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Hold the sender until every owed write has come out, then let the block settle
  task automatic wait_drained();
    in_push <= 1'b0;
    do @(posedge clk); while (pending_writes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both drive settings while the block is idle
  task automatic apply_config(input logic lba_ok, input logic slave);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LBA_SUPPORTED;
    cfg_wdata <= lba_ok;
    @(posedge clk);
    cfg_index <= CFG_DRIVE_IS_SLAVE;
    cfg_wdata <= slave;
    @(posedge clk);
    cfg_we       <= 1'b0;
    drive_lba_ok  = lba_ok;
    drive_slave   = slave;
    @(posedge clk);
  endtask

  // Sender: reset, directed rows, then random phases under every drive setting
  initial begin : sender
    int burst_left;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first rows run on the reset settings, so nothing is written before them
    foreach (dir_rows[i]) begin
      if (dir_rows[i].lba_ok != drive_lba_ok || dir_rows[i].slave != drive_slave)
        apply_config(dir_rows[i].lba_ok, dir_rows[i].slave);
      issue_request(dir_rows[i]);
      rest_sender($urandom_range(0, 3));
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      // cycle through all four settings; each change drains the block first
      apply_config(p % 4 == 0 || p % 4 == 2, p % 4 == 1 || p % 4 == 2);
      burst_left = 0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // one phase starves the receiver while items keep coming
        if (p == 3 && k == 2) hold_req = 1'b1;
        issue_request(random_request());
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 8);
          // every third phase runs back-to-back with no gaps at all
          if (p % 3 != 1) rest_sender($urandom_range(1, 12));
        end
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_writes.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Receiver: stretches of steady, random and patterned stalls, plus one long hold-off
  initial begin : receiver
    int style;
    int len;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      style = $urandom_range(0, 3);
      len   = $urandom_range(4, 40);
      for (int c = 0; c < len; c++) begin
        if (hold_req) begin
          hold_req = 1'b0;
          out_pop <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end else begin
          case (style)
            0:       out_pop <= 1'b1;
            1:       out_pop <= 1'($urandom_range(0, 1));
            2:       out_pop <= ($urandom_range(0, 7) != 0);
            default: out_pop <= (c % 5 != 4);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Compare every accepted write with the oldest one owed
  always @(posedge clk) begin : check_writes
    tf_write_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_writes.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("%0t: unexpected write id=%0d value=%02h mode=%0d last=%0b", $realtime,
                   out_reg_id, out_reg_value, out_addressing_mode, out_last_write);
        mismatches++;
      end else begin
        want = pending_writes.pop_front();
        if (out_reg_id !== want.reg_id || out_reg_value !== want.value ||
            out_addressing_mode !== want.mode || out_last_write !== want.last) begin
          if (mismatches < REPORT_LIMIT)
            $display("%0t: expected id=%0d value=%02h mode=%0d last=%0b, got id=%0d value=%02h mode=%0d last=%0b",
                     $realtime, want.reg_id, want.value, want.mode, want.last,
                     out_reg_id, out_reg_value, out_addressing_mode, out_last_write);
          mismatches++;
        end
      end
    end
  end

  // Hard stop if the run hangs
  initial begin : watchdog
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
